// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescape core: result kinds
// and the decoded packet that travels from the decoder to the output side.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  // One decoded input byte: cnt results (1..3), all of kind `kind`.
  typedef struct packed {
    logic [1:0] cnt;
    kind_e      kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } pkt_t;

endpackage

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Decoder: takes one text byte per cycle unless the queue is full, tracks
// string and escape state, and turns each byte into a 0..3 result packet.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  output logic          in_ready_o,
  input  logic          full_i,
  output logic          push_o,
  output jsu_pkg::pkt_t pkt_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU = 8'h75;

  phase_e      phase_q, phase_d;
  logic [11:0] acc_q, acc_d;
  logic        accept;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic [15:0] code;
  pkt_t        pkt;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = in_byte_i[3:0];
    end else if ((in_byte_i >= 8'h61 && in_byte_i <= 8'h66) ||
                 (in_byte_i >= 8'h41 && in_byte_i <= 8'h46)) begin
      hex_val = in_byte_i[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = 8'h00;
    unique case (in_byte_i)
      8'h22:   esc_val = 8'h22;
      8'h5C:   esc_val = 8'h5C;
      8'h2F:   esc_val = 8'h2F;
      8'h62:   esc_val = 8'h08;
      8'h66:   esc_val = 8'h0C;
      8'h6E:   esc_val = 8'h0A;
      8'h72:   esc_val = 8'h0D;
      8'h74:   esc_val = 8'h09;
      default: esc_ok = 1'b0;
    endcase
  end

  assign code = {acc_q, hex_val};

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    pkt      = '0;
    pkt.kind = KIND_DATA;
    unique case (phase_q)
      PH_STR: begin
        if (in_byte_i == ChQuote) begin
          pkt.cnt  = 2'd1;
          pkt.kind = KIND_END;
          phase_d  = PH_IDLE;
        end else if (in_byte_i == ChBslash) begin
          phase_d = PH_ESC;
        end else if (in_byte_i < 8'h20) begin
          pkt.cnt  = 2'd1;
          pkt.kind = KIND_ERR;
          phase_d  = PH_IDLE;
        end else begin
          pkt.cnt = 2'd1;
          pkt.b0  = in_byte_i;
        end
      end
      PH_ESC: begin
        if (in_byte_i == ChU) begin
          acc_d   = '0;
          phase_d = PH_HEX1;
        end else if (esc_ok) begin
          pkt.cnt = 2'd1;
          pkt.b0  = esc_val;
          phase_d = PH_STR;
        end else begin
          pkt.cnt  = 2'd1;
          pkt.kind = KIND_ERR;
          phase_d  = PH_IDLE;
        end
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        if (!hex_ok) begin
          pkt.cnt  = 2'd1;
          pkt.kind = KIND_ERR;
          phase_d  = PH_IDLE;
        end else if (phase_q != PH_HEX4) begin
          acc_d   = code[11:0];
          phase_d = phase_e'(phase_q + 3'd1);
        end else begin
          acc_d   = code[11:0];
          phase_d = PH_STR;
          if (code[15:7] == '0) begin
            pkt.cnt = 2'd1;
            pkt.b0  = code[7:0];
          end else if (code[15:11] == '0) begin
            pkt.cnt = 2'd2;
            pkt.b0  = {3'b110, code[10:6]};
            pkt.b1  = {2'b10, code[5:0]};
          end else begin
            pkt.cnt = 2'd3;
            pkt.b0  = {4'b1110, code[15:12]};
            pkt.b1  = {2'b10, code[11:6]};
            pkt.b2  = {2'b10, code[5:0]};
          end
        end
      end
      default: begin
        if (in_byte_i == ChQuote) begin
          phase_d = PH_STR;
        end else begin
          pkt.cnt  = 2'd1;
          pkt.kind = KIND_ERR;
          phase_d  = PH_IDLE;
        end
      end
    endcase
  end

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && (pkt.cnt != 2'd0);
  assign pkt_o      = pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
    end
  end

endmodule

// File: rtl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short packet queue between decoder and output serializer.
// ----------------------------------------------------------------------------
module jsu_fifo #(
  parameter int unsigned Depth = jsu_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::pkt_t pkt_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jsu_pkg::pkt_t head_o
);
  import jsu_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  pkt_t            mem_q [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastAddr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastAddr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Output serializer: unless out_ready stalls it, walks the head packet one
// result per cycle into the output register; pops it after its last result.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  jsu_pkg::pkt_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    kind_o,
  output logic [7:0]    data_byte_o,
  output logic          last_o
);
  import jsu_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       load, emit, is_last;
  logic [7:0] sel_byte;

  assign load    = !valid_q || out_ready_i;
  assign emit    = load && !empty_i;
  assign is_last = (idx_q == head_i.cnt - 2'd1);
  assign pop_o   = emit && is_last;

  always_comb begin
    case (idx_q)
      2'd1:    sel_byte = head_i.b1;
      2'd2:    sel_byte = head_i.b2;
      default: sel_byte = head_i.b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= !empty_i;
      if (emit) begin
        idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= head_i.kind;
      data_q <= sel_byte;
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign data_byte_o = data_q;
  assign last_o      = last_q;

endmodule

// File: rtl/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Byte-serial decoder for quoted JSON strings with \uXXXX to UTF-8 output.
// ----------------------------------------------------------------------------
// Accepts one byte of JSON text per cycle while the packet queue is not full.
// Each byte yields zero to three results (decoded byte, end of string, or
// error), with last set on the final result of that byte; a result passes
// through the packet queue and then the output register. The output side
// emits one result per cycle while the output register is free or taken,
// so a \u escape that expands to three UTF-8 bytes holds it for all three;
// a packet queue of QueueDepth entries between decoder and output register
// absorbs these bursts, and input ready drops only when the queue is full.
// Bytes already given for a string that later fails are not withdrawn.
module json_string_unescape_core #(
  parameter int unsigned QueueDepth = jsu_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] data_byte_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic push, full, pop, empty;
  pkt_t pkt, head;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_byte_i  (in_byte_i),
    .in_ready_o (in_ready_o),
    .full_i     (full),
    .push_o     (push),
    .pkt_o      (pkt)
  );

  jsu_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pkt_i   (pkt),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .data_byte_o (data_byte_o),
    .last_o      (last_o)
  );

endmodule
